// ===== src/dhp_pkg.sv =====
// Types, constants and helper functions shared by the drive heading controller.
package dhp_pkg;

  localparam int GAIN_W = 24;
  localparam int POS_W  = 24;
  localparam int ERR_W  = 25;
  localparam int DIFF_W = 26;
  localparam int ACC_W  = 32;
  localparam int LIM_W  = 15;
  localparam int CMD_W  = 17;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 3;

  localparam int PROD_P_W = ERR_W + GAIN_W + 1;
  localparam int PROD_I_W = ACC_W + GAIN_W + 1;
  localparam int PROD_D_W = DIFF_W + GAIN_W + 1;
  localparam int SUM_W    = PROD_I_W + 2;
  localparam int SHIFT    = 10;
  localparam int SCALED_W = SUM_W - SHIFT;

  localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TURN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [IDX_W-1:0] REG_DRIVE_P = 3'd0;
  localparam logic [IDX_W-1:0] REG_DRIVE_I = 3'd1;
  localparam logic [IDX_W-1:0] REG_DRIVE_D = 3'd2;
  localparam logic [IDX_W-1:0] REG_HOLD_P  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HOLD_I  = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOLD_D  = 3'd5;
  localparam logic [IDX_W-1:0] REG_TURN_P  = 3'd6;
  localparam logic [IDX_W-1:0] REG_TURN_D  = 3'd7;

  localparam logic [GAIN_W-1:0] TURN_I_GAIN_DEF = 24'd0;

  localparam logic signed [ERR_W-1:0] WIN_DIST_LO = 25'sd64;
  localparam logic signed [ERR_W-1:0] WIN_DIST_HI = 25'sd3072;
  localparam logic signed [ERR_W-1:0] WIN_HEAD_LO = 25'sd128;
  localparam logic signed [ERR_W-1:0] WIN_HEAD_HI = 25'sd2560;
  localparam logic signed [ERR_W-1:0] HALF_TURN   = 25'sd46080;
  localparam logic signed [ERR_W-1:0] FULL_TURN   = 25'sd92160;
  localparam logic signed [ERR_W-1:0] KICK_ERR    = 25'sd102;
  localparam logic signed [CMD_W-1:0] KICK_LIMIT  = 17'sd1392;
  localparam logic signed [CMD_W-1:0] KICK_VALUE  = 17'sd1475;
  localparam logic signed [CMD_W-1:0] UNITY       = 17'sd16384;

  typedef struct packed {
    logic [GAIN_W-1:0] drive_p;
    logic [GAIN_W-1:0] drive_i;
    logic [GAIN_W-1:0] drive_d;
    logic [GAIN_W-1:0] hold_p;
    logic [GAIN_W-1:0] hold_i;
    logic [GAIN_W-1:0] hold_d;
    logic [GAIN_W-1:0] turn_p;
    logic [GAIN_W-1:0] turn_d;
  } dhp_gains_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [POS_W-1:0] target;
    logic signed [POS_W-1:0] measured_position;
    logic signed [POS_W-1:0] gyro_heading;
    logic [LIM_W-1:0]        max_output;
  } dhp_item_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  dist_err;
    logic signed [ACC_W-1:0]  dist_int;
    logic signed [DIFF_W-1:0] dist_de;
    logic signed [ERR_W-1:0]  head_err;
    logic signed [ACC_W-1:0]  head_int;
    logic signed [DIFF_W-1:0] head_de;
    logic                     turn;
    logic                     kick;
    logic [LIM_W-1:0]         lim;
  } dhp_oper_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] dist_p;
    logic signed [PROD_I_W-1:0] dist_i;
    logic signed [PROD_D_W-1:0] dist_d;
    logic signed [PROD_P_W-1:0] head_p;
    logic signed [PROD_I_W-1:0] head_i;
    logic signed [PROD_D_W-1:0] head_d;
    logic                       turn;
    logic                       kick;
    logic [LIM_W-1:0]           lim;
  } dhp_prod_t;

  function automatic logic signed [ACC_W-1:0] integrate(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ERR_W-1:0] e,
    input logic signed [ERR_W-1:0] lo,
    input logic signed [ERR_W-1:0] hi
  );
    logic signed [ACC_W:0]   sum;
    logic                    in_win;
    logic signed [ACC_W-1:0] res;
    in_win = ((e > lo) && (e < hi)) || ((e < -lo) && (e > -hi));
    sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - ERR_W){e[ERR_W-1]}}, e};
    if (!in_win) begin
      res = '0;
    end else if (sum[ACC_W] != sum[ACC_W-1]) begin
      res = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      res = sum[ACC_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [ERR_W-1:0] wrap_heading(
    input logic signed [ERR_W-1:0] e
  );
    logic signed [ERR_W-1:0] res;
    if (e > HALF_TURN) begin
      res = e - FULL_TURN;
    end else if (e < -HALF_TURN) begin
      res = e + FULL_TURN;
    end else begin
      res = e;
    end
    return res;
  endfunction

  function automatic logic signed [CMD_W-1:0] clamp_lim(
    input logic signed [SCALED_W-1:0] v,
    input logic [LIM_W-1:0]           lim
  );
    logic signed [SCALED_W-1:0] lim_s;
    logic signed [CMD_W-1:0]    lim_c;
    logic signed [CMD_W-1:0]    res;
    lim_s = $signed({{(SCALED_W - LIM_W){1'b0}}, lim});
    lim_c = $signed({{(CMD_W - LIM_W){1'b0}}, lim});
    if (v > lim_s) begin
      res = lim_c;
    end else if (v < -lim_s) begin
      res = -lim_c;
    end else begin
      res = v[CMD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [CMD_W-1:0] clamp_unity(
    input logic signed [CMD_W-1:0] v
  );
    logic signed [CMD_W-1:0] res;
    if (v > UNITY) begin
      res = UNITY;
    end else if (v < -UNITY) begin
      res = -UNITY;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== src/dhp_if.sv =====
// Handshake channel interfaces for command items, drive results and gain writes.
interface dhp_in_if import dhp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [POS_W-1:0] target;
  logic signed [POS_W-1:0] measured_position;
  logic signed [POS_W-1:0] gyro_heading;
  logic [LIM_W-1:0]        max_output;

  modport source (output valid, mode, target, measured_position, gyro_heading, max_output,
                  input ready);
  modport sink (input valid, mode, target, measured_position, gyro_heading, max_output,
                output ready);
endinterface

interface dhp_out_if import dhp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] left_drive;
  logic signed [CMD_W-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink (input valid, left_drive, right_drive, output ready);
endinterface

interface dhp_cfg_if import dhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [GAIN_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dhp_cfg.sv =====
// Gain register file written through the configuration channel.
module dhp_cfg import dhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dhp_cfg_if.sink    cfg,
  output dhp_gains_t gains
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DRIVE_P: gains.drive_p <= cfg.data;
        REG_DRIVE_I: gains.drive_i <= cfg.data;
        REG_DRIVE_D: gains.drive_d <= cfg.data;
        REG_HOLD_P:  gains.hold_p  <= cfg.data;
        REG_HOLD_I:  gains.hold_i  <= cfg.data;
        REG_HOLD_D:  gains.hold_d  <= cfg.data;
        REG_TURN_P:  gains.turn_p  <= cfg.data;
        REG_TURN_D:  gains.turn_d  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dhp_err.sv =====
// Error stage: loop errors, windowed integrals, derivatives and the loop state.
module dhp_err import dhp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      item_valid,
  input  dhp_item_t item,
  output logic      oper_valid,
  output dhp_oper_t oper
);

  logic signed [POS_W-1:0]  heading_setpoint;
  logic signed [ACC_W-1:0]  distance_integral;
  logic signed [ERR_W-1:0]  last_distance_error;
  logic signed [ACC_W-1:0]  heading_integral;
  logic signed [ERR_W-1:0]  last_heading_error;

  logic                     is_drive;
  logic                     is_turn;
  logic                     is_clear;
  logic                     fire;
  logic signed [POS_W-1:0]  setp;
  logic signed [ERR_W-1:0]  dist_err;
  logic signed [ERR_W-1:0]  head_err;
  logic signed [ACC_W-1:0]  dist_int_next;
  logic signed [ACC_W-1:0]  head_int_next;
  logic signed [DIFF_W-1:0] dist_de;
  logic signed [DIFF_W-1:0] head_de;
  dhp_oper_t                oper_next;

  assign is_drive = (item.mode == MODE_DRIVE);
  assign is_turn  = (item.mode == MODE_TURN);
  assign is_clear = (item.mode == MODE_CLEAR);
  assign fire     = item_valid && adv;

  assign setp = is_turn ? item.target : heading_setpoint;
  assign dist_err = {item.target[POS_W-1], item.target}
                  - {item.measured_position[POS_W-1], item.measured_position};
  assign head_err = wrap_heading({setp[POS_W-1], setp}
                                 - {item.gyro_heading[POS_W-1], item.gyro_heading});
  assign dist_int_next = integrate(distance_integral, dist_err, WIN_DIST_LO, WIN_DIST_HI);
  assign head_int_next = integrate(heading_integral, head_err, WIN_HEAD_LO, WIN_HEAD_HI);
  assign dist_de = {dist_err[ERR_W-1], dist_err}
                 - {last_distance_error[ERR_W-1], last_distance_error};
  assign head_de = {head_err[ERR_W-1], head_err}
                 - {last_heading_error[ERR_W-1], last_heading_error};

  always_comb begin
    oper_next.dist_err = dist_err;
    oper_next.dist_int = dist_int_next;
    oper_next.dist_de  = dist_de;
    oper_next.head_err = head_err;
    oper_next.head_int = head_int_next;
    oper_next.head_de  = head_de;
    oper_next.turn     = is_turn;
    oper_next.kick     = (head_err > KICK_ERR) || (head_err < -KICK_ERR);
    oper_next.lim      = item.max_output;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_setpoint    <= '0;
      distance_integral   <= '0;
      last_distance_error <= '0;
      heading_integral    <= '0;
      last_heading_error  <= '0;
      oper_valid          <= 1'b0;
    end else begin
      if (adv) begin
        oper_valid <= item_valid && (is_drive || is_turn);
      end
      if (fire && is_drive) begin
        distance_integral   <= dist_int_next;
        last_distance_error <= dist_err;
      end
      if (fire && is_turn) begin
        heading_setpoint <= item.target;
      end
      if (fire && (is_drive || is_turn)) begin
        heading_integral   <= head_int_next;
        last_heading_error <= head_err;
      end
      if (fire && is_clear) begin
        distance_integral   <= '0;
        last_distance_error <= '0;
        last_heading_error  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oper <= oper_next;
    end
  end

endmodule

// ===== src/dhp_mult.sv =====
// Product stage: the six gain multiplications of both loops, registered.
module dhp_mult import dhp_pkg::*; #(
  parameter logic [GAIN_W-1:0] TURN_I_GAIN = TURN_I_GAIN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  dhp_gains_t gains,
  input  logic       oper_valid,
  input  dhp_oper_t  oper,
  output logic       prod_valid,
  output dhp_prod_t  prod
);

  logic [GAIN_W-1:0] kp;
  logic [GAIN_W-1:0] ki;
  logic [GAIN_W-1:0] kd;
  dhp_prod_t         prod_next;

  assign kp = oper.turn ? gains.turn_p : gains.hold_p;
  assign ki = oper.turn ? TURN_I_GAIN  : gains.hold_i;
  assign kd = oper.turn ? gains.turn_d : gains.hold_d;

  always_comb begin
    prod_next.dist_p = oper.dist_err * $signed({1'b0, gains.drive_p});
    prod_next.dist_i = oper.dist_int * $signed({1'b0, gains.drive_i});
    prod_next.dist_d = oper.dist_de  * $signed({1'b0, gains.drive_d});
    prod_next.head_p = oper.head_err * $signed({1'b0, kp});
    prod_next.head_i = oper.head_int * $signed({1'b0, ki});
    prod_next.head_d = oper.head_de  * $signed({1'b0, kd});
    prod_next.turn   = oper.turn;
    prod_next.kick   = oper.kick;
    prod_next.lim    = oper.lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv) begin
      prod_valid <= oper_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== src/dhp_mix.sv =====
// Output stage: term sums, scaling, limits, minimum turn kick and arcade mixing.
module dhp_mix import dhp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    prod_valid,
  input  dhp_prod_t               prod,
  output logic                    res_valid,
  output logic signed [CMD_W-1:0] left_drive,
  output logic signed [CMD_W-1:0] right_drive
);

  logic signed [SUM_W-1:0] dist_sum;
  logic signed [SUM_W-1:0] head_sum;
  logic signed [CMD_W-1:0] fwd_lim;
  logic signed [CMD_W-1:0] turn_lim;
  logic signed [CMD_W-1:0] turn_kick;
  logic signed [CMD_W-1:0] fwd;
  logic signed [CMD_W-1:0] turn;
  logic signed [CMD_W-1:0] left_next;
  logic signed [CMD_W-1:0] right_next;

  assign dist_sum = {{(SUM_W - PROD_P_W){prod.dist_p[PROD_P_W-1]}}, prod.dist_p}
                  + {{(SUM_W - PROD_I_W){prod.dist_i[PROD_I_W-1]}}, prod.dist_i}
                  + {{(SUM_W - PROD_D_W){prod.dist_d[PROD_D_W-1]}}, prod.dist_d};
  assign head_sum = {{(SUM_W - PROD_P_W){prod.head_p[PROD_P_W-1]}}, prod.head_p}
                  + {{(SUM_W - PROD_I_W){prod.head_i[PROD_I_W-1]}}, prod.head_i}
                  + {{(SUM_W - PROD_D_W){prod.head_d[PROD_D_W-1]}}, prod.head_d};

  // The arithmetic shift by the top bits rounds toward minus infinity.
  assign fwd_lim  = clamp_lim(dist_sum[SUM_W-1:SHIFT], prod.lim);
  assign turn_lim = clamp_lim(head_sum[SUM_W-1:SHIFT], prod.lim);

  always_comb begin
    turn_kick = turn_lim;
    if (prod.turn && prod.kick) begin
      if ((turn_lim > 17'sd0) && (turn_lim <= KICK_LIMIT)) begin
        turn_kick = KICK_VALUE;
      end else if ((turn_lim < 17'sd0) && (turn_lim >= -KICK_LIMIT)) begin
        turn_kick = -KICK_VALUE;
      end
    end
  end

  assign fwd        = prod.turn ? '0 : clamp_unity(fwd_lim);
  assign turn       = clamp_unity(turn_kick);
  assign left_next  = fwd - turn;
  assign right_next = fwd + turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_drive  <= left_next;
      right_drive <= right_next;
    end
  end

endmodule

// ===== src/drive_heading_pid.sv =====
// Top level of the differential-drive distance and heading controller.
//
// Each command item is taken into an input register and passes through three more registered
// steps (errors and loop state, gain products, sums with limits and mixing) to a left and right
// command. A new item is accepted in every cycle in which the whole pipeline advances; it holds
// only while a finished result waits at the output and is not taken. Clear items and items with
// the unused mode code update or keep the loop state and produce no result. The loop state
// (integrals, last errors, heading setpoint) is updated as an item leaves the input register, so
// each item sees the state left by the one before it. Gains must be written through the
// configuration channel only while no item is in flight; the block does not enforce it.
module drive_heading_pid import dhp_pkg::*; #(
  parameter logic [GAIN_W-1:0] TURN_I_GAIN = TURN_I_GAIN_DEF
) (
  input logic      clk,
  input logic      rst,
  dhp_in_if.sink   cmd,
  dhp_out_if.source drive,
  dhp_cfg_if.sink  cfg
);

  logic       adv;
  logic       item_valid;
  dhp_item_t  item;
  dhp_gains_t gains;
  logic       oper_valid;
  dhp_oper_t  oper;
  logic       prod_valid;
  dhp_prod_t  prod;
  logic       res_valid;

  assign adv       = !res_valid || drive.ready;
  assign cmd.ready = adv;
  assign drive.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (adv) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item.mode              <= cmd.mode;
      item.target            <= cmd.target;
      item.measured_position <= cmd.measured_position;
      item.gyro_heading      <= cmd.gyro_heading;
      item.max_output        <= cmd.max_output;
    end
  end

  dhp_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .gains (gains)
  );

  dhp_err u_err (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .oper_valid (oper_valid),
    .oper       (oper)
  );

  dhp_mult #(
    .TURN_I_GAIN (TURN_I_GAIN)
  ) u_mult (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .gains      (gains),
    .oper_valid (oper_valid),
    .oper       (oper),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  dhp_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .prod_valid  (prod_valid),
    .prod        (prod),
    .res_valid   (res_valid),
    .left_drive  (drive.left_drive),
    .right_drive (drive.right_drive)
  );

endmodule
